FILE: rtl/fifs_pkg.sv
// Shared types and constants for the float integer/fraction split pipeline.
package fifs_pkg;

  localparam int unsigned DMant = 52;
  localparam int unsigned DExpw = 11;
  localparam int unsigned SMant = 23;
  localparam int unsigned SExpw = 8;
  localparam int unsigned MantW = 52;
  localparam int unsigned PosW = 6;

  // Result class decided in the first stage.
  typedef enum logic [1:0] {
    CLS_FRAC = 2'd0,
    CLS_SMALL = 2'd1,
    CLS_WHOLE = 2'd2,
    CLS_NAN = 2'd3
  } cls_t;

  // Stage-one output: fields decoded and low bits isolated.
  typedef struct packed {
    logic             sp;
    logic [63:0]      x;
    logic [63:0]      sgn;
    logic [63:0]      ip;
    cls_t             cls;
    logic [MantW-1:0] r;
    logic [PosW-1:0]  k;
  } dec_t;

  // Stage-two output: leading-one position of the fraction bits.
  typedef struct packed {
    dec_t            d;
    logic [PosW-1:0] p;
    logic            rz;
  } lz_t;

endpackage

FILE: rtl/fifs_decode.sv
// Stage one: decode the format, classify, and mask the integer part.
module fifs_decode (
  input  logic           sp,
  input  logic [63:0]    value,
  output fifs_pkg::dec_t dec
);

  logic [63:0] x;
  logic [10:0] be;
  logic [51:0] m;
  logic [11:0] e;
  logic [6:0]  kw;
  logic [51:0] low;
  logic        emax;
  logic        below_one;
  logic        whole;

  always_comb begin
    x = sp ? {32'd0, value[31:0]} : value;
    if (sp) begin
      be = {3'd0, x[30:23]};
      m = {29'd0, x[22:0]};
      emax = (x[30:23] == 8'hFF);
      below_one = (x[30:23] < 8'd127);
      e = {4'd0, x[30:23]} - 12'd127;
      whole = !below_one && (e >= 12'd23);
      kw = 7'd23 - e[6:0];
      dec.sgn = {32'd0, x[31], 31'd0};
    end else begin
      be = x[62:52];
      m = x[51:0];
      emax = (be == 11'h7FF);
      below_one = (be < 11'd1023);
      e = {1'b0, be} - 12'd1023;
      whole = !below_one && (e >= 12'd52);
      kw = 7'd52 - e[6:0];
      dec.sgn = {x[63], 63'd0};
    end
    low = (52'd1 << kw[5:0]) - 52'd1;
    if (whole || below_one || emax) low = '0;
    dec.sp = sp;
    dec.x = x;
    dec.k = kw[5:0];
    dec.r = m & low;
    dec.ip = x & ~{12'd0, low};
    priority if (emax && m != '0) dec.cls = fifs_pkg::CLS_NAN;
    else if (emax || whole) dec.cls = fifs_pkg::CLS_WHOLE;
    else if (below_one) dec.cls = fifs_pkg::CLS_SMALL;
    else dec.cls = fifs_pkg::CLS_FRAC;
  end

endmodule

FILE: rtl/fifs_lzc.sv
// Stage two: find the top set bit of the fraction bits.
module fifs_lzc (
  input  fifs_pkg::dec_t dec,
  output fifs_pkg::lz_t  lz
);

  always_comb begin
    lz.d = dec;
    lz.p = '0;
    lz.rz = (dec.r == '0);
    for (int i = 0; i < 52; i++) begin
      if (dec.r[i]) lz.p = 6'(i);
    end
  end

endmodule

FILE: rtl/fifs_pack.sv
// Stage three: normalize the fraction and assemble both results.
module fifs_pack (
  input  fifs_pkg::lz_t lz,
  output logic [63:0]   ip,
  output logic [63:0]   fp
);

  logic [51:0] sh;
  logic [10:0] nexp;
  logic [5:0]  amt;
  logic [63:0] q;

  always_comb begin
    amt = (lz.d.sp ? 6'd23 : 6'd52) - lz.p;
    sh = lz.d.r << amt;
    q = lz.d.x | (lz.d.sp ? 64'h0040_0000 : 64'h0008_0000_0000_0000);
    if (lz.d.sp) begin
      nexp = 11'd127 + {5'd0, lz.p} - {5'd0, lz.d.k};
    end else begin
      nexp = 11'd1023 + {5'd0, lz.p} - {5'd0, lz.d.k};
    end
    unique case (lz.d.cls)
      fifs_pkg::CLS_NAN: begin
        ip = q;
        fp = q;
      end
      fifs_pkg::CLS_WHOLE: begin
        ip = lz.d.x;
        fp = lz.d.sgn;
      end
      fifs_pkg::CLS_SMALL: begin
        ip = lz.d.sgn;
        fp = lz.d.x;
      end
      default: begin
        ip = lz.d.ip;
        if (lz.rz) fp = lz.d.sgn;
        else if (lz.d.sp) fp = lz.d.sgn | {32'd0, 1'b0, nexp[7:0], sh[22:0]};
        else fp = lz.d.sgn | {1'b0, nexp, sh};
      end
    endcase
  end

endmodule

FILE: rtl/float_integer_fraction_split.sv
// Top level of the pipelined float integer/fraction split.
// Splits a binary64 (command 0) or binary32 (command 1, low 32 bits) value into
// its truncated integer part and its exact, renormalized fraction part. The
// pipeline has three register stages (decode and mask, leading-one search,
// normalize and pack) and accepts one request every cycle when not stalled; each
// request passes through the decode, leading-one and output registers in turn.
// A stall freezes full stages with no empty stage after them; others keep filling.
module float_integer_fraction_split (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_integer_part,
  output logic [63:0] out_fraction_part
);

  fifs_pkg::dec_t dec_c, dec_r;
  fifs_pkg::lz_t  lz_c, lz_r;
  logic [63:0]    ip_c, fp_c;
  logic           v1_r, v2_r, v3_r;
  logic           en1, en2, en3;

  fifs_decode u_dec (.sp(in_command), .value(in_value), .dec(dec_c));
  fifs_lzc    u_lzc (.dec(dec_r), .lz(lz_c));
  fifs_pack   u_pack (.lz(lz_r), .ip(ip_c), .fp(fp_c));

  // Each stage advances when the next one frees up.
  assign en3 = !v3_r || !out_stall;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;
  assign out_valid = v3_r;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1) dec_r <= dec_c;
    if (en2) lz_r <= lz_c;
    if (en3) begin
      out_integer_part <= ip_c;
      out_fraction_part <= fp_c;
    end
  end

endmodule

FILE: tb/tb_float_integer_fraction_split.sv
// Self-checking testbench for the float integer/fraction split block.
`timescale 1ns / 1ps

// Scoreboard: predicts the split of each accepted request and checks results in order.
class split_scoreboard;
  bit [63:0] int_q[$];
  bit [63:0] frac_q[$];
  int errors;

  // Splits one pattern of the given format into integer and fraction patterns.
  static function void split_pattern(input bit [63:0] x, input int ml, input int ew,
                                     output bit [63:0] ip, output bit [63:0] fp);
    bit [63:0] mmask, emax, bias, s, be, m, e, low, r, nexp;
    int k, p;
    mmask = (64'd1 << ml) - 1;
    emax = (64'd1 << ew) - 1;
    bias = emax >> 1;
    s = x & (64'd1 << (ml + ew));
    be = (x >> ml) & emax;
    m = x & mmask;
    if (be == emax) begin
      if (m != 0) begin
        ip = x | (64'd1 << (ml - 1));
        fp = ip;
      end else begin
        ip = x;
        fp = s;
      end
      return;
    end
    if (be < bias) begin
      ip = s;
      fp = x;
      return;
    end
    e = be - bias;
    if (e >= ml) begin
      ip = x;
      fp = s;
      return;
    end
    k = ml - int'(e);
    low = (64'd1 << k) - 1;
    r = m & low;
    ip = x & ~low;
    if (r == 0) begin
      fp = s;
    end else begin
      // Leading-one position of the fraction bits.
      p = 0;
      for (int i = 0; i < 64; i++) if (r[i]) p = i;
      nexp = bias + p - k;
      fp = s | (nexp << ml) | ((r << (ml - p)) & mmask);
    end
  endfunction

  // Notes an accepted request and queues its expected split.
  function void note_request(bit single, bit [63:0] value);
    bit [63:0] ip, fp;
    if (!single) begin
      split_pattern(value, 52, 11, ip, fp);
    end else begin
      split_pattern({32'd0, value[31:0]}, 23, 8, ip, fp);
      ip &= 64'hFFFF_FFFF;
      fp &= 64'hFFFF_FFFF;
    end
    int_q.push_back(ip);
    frac_q.push_back(fp);
  endfunction

  // Checks one accepted result against the oldest expectation.
  function void check_result(bit [63:0] ip, bit [63:0] fp);
    bit [63:0] eip, efp;
    if (int_q.size() == 0) begin
      $display("%0t: unexpected result int=%h frac=%h", $time, ip, fp);
      errors++;
      return;
    end
    eip = int_q.pop_front();
    efp = frac_q.pop_front();
    if (ip !== eip) begin
      $display("%0t: integer part expected %h actual %h", $time, eip, ip);
      errors++;
    end
    if (fp !== efp) begin
      $display("%0t: fraction part expected %h actual %h", $time, efp, fp);
      errors++;
    end
  endfunction
endclass

module tb_float_integer_fraction_split;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [63:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_integer_part;
  logic [63:0] out_fraction_part;

  split_scoreboard sb;
  bit sending_done;
  bit hold_receiver;
  int hold_cycles;

  float_integer_fraction_split u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_integer_part(out_integer_part), .out_fraction_part(out_fraction_part)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Random gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one request and waits for it to be accepted.
  task automatic send_request(bit single, bit [63:0] value);
    in_valid <= 1'b1;
    in_command <= single;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    sb.note_request(single, value);
  endtask

  // Sends a request followed by a random gap.
  task automatic send_with_gap(bit single, bit [63:0] value);
    int g;
    send_request(single, value);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Builds a random pattern biased toward exponents near the binary point.
  function automatic bit [63:0] random_pattern(bit single);
    bit [63:0] v;
    int roll;
    v = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (!single) begin
      if (roll < 70) v[62:52] = 11'(1023 + $urandom_range(0, 60) - 6);
      else if (roll < 78) v[62:52] = 11'h7FF;
      else if (roll < 84) v[62:52] = 11'd0;
      if ($urandom_range(0, 9) == 0) v[51:0] = v[51:0] & ({52{1'b1}} << $urandom_range(0, 52));
    end else begin
      if (roll < 70) v[30:23] = 8'(127 + $urandom_range(0, 30) - 6);
      else if (roll < 78) v[30:23] = 8'hFF;
      else if (roll < 84) v[30:23] = 8'd0;
      if ($urandom_range(0, 9) == 0) v[22:0] = v[22:0] & ({23{1'b1}} << $urandom_range(0, 23));
    end
    return v;
  endfunction

  // Stimulus.
  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = 1'b0;
    in_value = 64'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: zeros, subnormals, one, half, integers, infinities, NaNs, extremes.
    send_with_gap(1'b0, 64'h0000_0000_0000_0000);
    send_with_gap(1'b0, 64'h8000_0000_0000_0000);
    send_with_gap(1'b0, 64'h0000_0000_0000_0001);
    send_with_gap(1'b0, 64'h3FF0_0000_0000_0000);
    send_with_gap(1'b0, 64'hBFE0_0000_0000_0000);
    send_with_gap(1'b0, 64'h400C_0000_0000_0000);
    send_with_gap(1'b0, 64'hC00C_0000_0000_0001);
    send_with_gap(1'b0, 64'h4330_0000_0000_0001);
    send_with_gap(1'b0, 64'h432F_FFFF_FFFF_FFFF);
    send_with_gap(1'b0, 64'h7FEF_FFFF_FFFF_FFFF);
    send_with_gap(1'b0, 64'h7FF0_0000_0000_0000);
    send_with_gap(1'b0, 64'hFFF0_0000_0000_0000);
    send_with_gap(1'b0, 64'h7FF0_0000_0000_0001);
    send_with_gap(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_with_gap(1'b1, 64'hFFFF_FFFF_0000_0000);
    send_with_gap(1'b1, 64'h0000_0000_8000_0001);
    send_with_gap(1'b1, 64'h0000_0000_3F80_0000);
    send_with_gap(1'b1, 64'hABCD_1234_4060_0001);
    send_with_gap(1'b1, 64'h0000_0000_4B7F_FFFF);
    send_with_gap(1'b1, 64'h0000_0000_4B00_0001);
    send_with_gap(1'b1, 64'h0000_0000_FF80_0000);
    send_with_gap(1'b1, 64'h0000_0000_7F80_0001);
    send_with_gap(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_with_gap(1'b1, 64'h0000_0000_7F7F_FFFF);
    // Random part, with one back-to-back burst while the receiver holds off.
    for (int i = 0; i < 1400; i++) begin
      bit single;
      single = $urandom_range(0, 1);
      if (i == 300) hold_receiver = 1'b1;
      if (i >= 300 && i < 340) send_request(single, random_pattern(single));
      else send_with_gap(single, random_pattern(single));
      if (i == 700) begin
        // Pause until every expected result has come back.
        in_valid <= 1'b0;
        while (sb.int_q.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls plus one long hold-off.
  initial begin
    int g;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_receiver && hold_cycles == 0) begin
        out_stall <= 1'b1;
        for (hold_cycles = 1; hold_cycles <= 60; hold_cycles++) @(posedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_integer_part, out_fraction_part);
  end

  // End of run.
  initial begin
    wait (sending_done);
    while (sb.int_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.int_q.size() == 0) begin
      $display("tb_float_integer_fraction_split: clean");
    end else begin
      $display("tb_float_integer_fraction_split: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("tb_float_integer_fraction_split: errors");
    $finish;
  end
endmodule
